@@ rtl/core/ocp_pkg.sv @@
// ocp_pkg: shared types, codes and constant tables for the orbit camera block.
// No dependencies; imported by ocp_cordic and orbit_camera_position_update.
package ocp_pkg;

  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned TRIG_W   = 32;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] TENTH_RAD_TURN_Q32 = 32'd68356572;

  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CAZ  = 7'b0000010,
    S_CEL  = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_MUL3 = 7'b0100000,
    S_DONE = 7'b1000000
  } ocp_state_e;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } ocp_trig_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0:    r = 32'h20000000;
        5'd1:    r = 32'h12E4051E;
        5'd2:    r = 32'h09FB385B;
        5'd3:    r = 32'h051111D4;
        5'd4:    r = 32'h028B0D43;
        5'd5:    r = 32'h0145D7E1;
        5'd6:    r = 32'h00A2F61E;
        5'd7:    r = 32'h00517C55;
        5'd8:    r = 32'h0028BE53;
        5'd9:    r = 32'h00145F2F;
        5'd10:   r = 32'h000A2F98;
        5'd11:   r = 32'h000517CC;
        5'd12:   r = 32'h00028BE6;
        5'd13:   r = 32'h000145F3;
        5'd14:   r = 32'h0000A2FA;
        5'd15:   r = 32'h0000517D;
        5'd16:   r = 32'h000028BE;
        5'd17:   r = 32'h0000145F;
        5'd18:   r = 32'h00000A30;
        5'd19:   r = 32'h00000518;
        5'd20:   r = 32'h0000028C;
        5'd21:   r = 32'h00000146;
        5'd22:   r = 32'h000000A3;
        5'd23:   r = 32'h00000051;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage

@@ rtl/core/ocp_cordic.sv @@
// ocp_cordic: iterative CORDIC rotation giving cos and sin (Q1.30) of a binary angle.
// One iteration per cycle after quadrant folding. Depends on ocp_pkg.
module ocp_cordic import ocp_pkg::*; #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output ocp_trig_t             trig_o
);

  localparam int unsigned CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [1:0]                 quad_q, quad_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;

  logic [ANGLE_BITS-1:0]      a_plus;
  logic [ANGLE_BITS-1:0]      ru;
  logic [1:0]                 quad_in;
  logic signed [CORDIC_W-1:0] dx, dy, at;
  logic                       last;

  assign a_plus  = angle_i + EIGHTH;
  assign quad_in = a_plus[ANGLE_BITS-1 -: 2];
  assign ru      = angle_i - {quad_in, {(ANGLE_BITS-2){1'b0}}};

  assign dx   = y_q >>> cnt_q;
  assign dy   = x_q >>> cnt_q;
  assign at   = CORDIC_W'(atan_turn(ATAN_IDX_W'(cnt_q)));
  assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quad_d = quad_in;
      x_d    = CORDIC_GAIN_Q30;
      y_d    = '0;
      z_d    = CORDIC_W'($signed(ru)) <<< (32 - ANGLE_BITS);
    end else if (busy_q) begin
      if (!z_q[CORDIC_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // undo the quadrant fold
  always_comb begin
    trig_o.done = done_q;
    case (quad_q)
      2'd0: begin
        trig_o.cos_v = TRIG_W'(x_q);
        trig_o.sin_v = TRIG_W'(y_q);
      end
      2'd1: begin
        trig_o.cos_v = TRIG_W'(-y_q);
        trig_o.sin_v = TRIG_W'(x_q);
      end
      2'd2: begin
        trig_o.cos_v = TRIG_W'(-x_q);
        trig_o.sin_v = TRIG_W'(-y_q);
      end
      default: begin
        trig_o.cos_v = TRIG_W'(y_q);
        trig_o.sin_v = TRIG_W'(-x_q);
      end
    endcase
  end

endmodule

@@ rtl/core/orbit_camera_position_update.sv @@
// orbit_camera_position_update: orbit angles update and spherical-to-cartesian camera position.
// Azimuth then elevation run in turn through the single CORDIC unit, followed by the
// multiply-and-saturate states S_MUL1, S_MUL2, S_MUL3 around one 32x32 multiplier.
// A new item is taken only in S_IDLE, after the previous result has been loaded to the output.
// Reset: both angles to 0.1 rad, radius 6, no result pending. Depends on ocp_pkg, ocp_cordic.
module orbit_camera_position_update import ocp_pkg::*; #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_orbit_radius_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         horiz_dir_i,
  input  logic [1:0]         vert_dir_i,
  input  logic [15:0]        step_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic               up_negative_o,
  output logic [15:0]        azimuth_out_o,
  output logic [15:0]        elevation_out_o
);

  localparam logic [ANGLE_BITS-1:0] ANGLE_RST = ANGLE_BITS'(
    ((64'(TENTH_RAD_TURN_Q32) << ANGLE_BITS) + 64'h8000_0000) >> 32);

  ocp_state_e              state_q, state_d;
  logic [ANGLE_BITS-1:0]   az_q, az_d, el_q, el_d;
  logic [2:0]              radius_q;
  logic                    out_valid_q;
  logic                    accept;
  logic                    out_load;

  logic [ANGLE_BITS+15:0]  step_ext;
  logic [ANGLE_BITS-1:0]   step;
  logic [ANGLE_BITS+15:0]  az_ext, el_ext;

  logic                    cor_start;
  logic [ANGLE_BITS-1:0]   cor_angle;
  ocp_trig_t               trig;

  logic signed [TRIG_W-1:0] ca_q, sa_q;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [63:0]       prod, prod_q;
  logic signed [39:0]       rad_s, prod_sh, scaled, y_scaled;
  logic [15:0]              px_q, py_q, pz_q;

  function automatic logic [ANGLE_BITS-1:0] apply_dir(input logic [ANGLE_BITS-1:0] ang,
                                                      input logic [1:0] dir,
                                                      input logic [ANGLE_BITS-1:0] stp);
    logic [ANGLE_BITS-1:0] r;
    begin
      case (dir)
        DIR_FWD:  r = ang + stp;
        DIR_BACK: r = ang - stp;
        default:  r = ang;
      endcase
      return r;
    end
  endfunction

  function automatic logic [15:0] sat_q12(input logic signed [39:0] v);
    logic signed [39:0] t;
    begin
      t = (v + 40'sd131072) >>> 18;
      if (t > 40'sd32767) return 16'h7FFF;
      else if (t < -40'sd32768) return 16'h8000;
      else return t[15:0];
    end
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign step_ext = {{ANGLE_BITS{1'b0}}, step_angle_i};
  assign step     = step_ext[ANGLE_BITS-1:0];
  assign az_d     = accept ? apply_dir(az_q, horiz_dir_i, step) : az_q;
  assign el_d     = accept ? apply_dir(el_q, vert_dir_i, step) : el_q;

  assign cor_start = accept || ((state_q == S_CAZ) && trig.done);
  assign cor_angle = accept ? az_d : el_q;

  ocp_cordic #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cor_start),
    .angle_i(cor_angle),
    .trig_o (trig)
  );

  // shared multiplier: cos(el)*sin(az), then cos(el)*cos(az)
  assign mul_b    = (state_q == S_MUL1) ? sa_q : ca_q;
  assign prod     = trig.cos_v * mul_b;
  assign rad_s    = 40'({1'b0, radius_q});
  assign prod_sh  = 40'(prod_q >>> 30);
  assign scaled   = prod_sh * rad_s;
  assign y_scaled = 40'(trig.sin_v) * rad_s;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_CAZ;
      S_CAZ:  if (trig.done) state_d = S_CEL;
      S_CEL:  if (trig.done) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      az_q        <= ANGLE_RST;
      el_q        <= ANGLE_RST;
      radius_q    <= 3'd6;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      az_q    <= az_d;
      el_q    <= el_d;
      if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_orbit_radius_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign az_ext = {16'h0, az_q};
  assign el_ext = {16'h0, el_q};

  always_ff @(posedge clk_i) begin
    if ((state_q == S_CAZ) && trig.done) begin
      ca_q <= trig.cos_v;
      sa_q <= trig.sin_v;
    end
    if ((state_q == S_MUL1) || (state_q == S_MUL2)) prod_q <= prod;
    if (state_q == S_MUL1) py_q <= sat_q12(y_scaled);
    if (state_q == S_MUL2) px_q <= sat_q12(scaled);
    if (state_q == S_MUL3) pz_q <= sat_q12(scaled);
    if (out_load) begin
      pos_x_o         <= px_q;
      pos_y_o         <= py_q;
      pos_z_o         <= pz_q;
      up_negative_o   <= el_q[ANGLE_BITS-1] ^ el_q[ANGLE_BITS-2];
      azimuth_out_o   <= az_ext[15:0];
      elevation_out_o <= el_ext[15:0];
    end
  end

  assign out_valid_o = out_valid_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_accept_starts_az: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CAZ)) else $error("item accepted but azimuth pass not started");

  a_done_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.done |-> (state_q == S_CAZ || state_q == S_CEL))
    else $error("CORDIC finished outside a rotation pass");

  a_angles_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> ($stable(az_q) && $stable(el_q)))
    else $error("angle state changed while an item is in flight");

endmodule
